### rtl/core/assert_macros.svh
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ON(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/sjcc_pkg.sv
`default_nettype none
package sjcc_pkg;

   // widths of the fields
   localparam int ANGLE_W = 8;
   localparam int STEP_W  = 3;
   localparam int DUTY_W  = 9;
   localparam int JOINT_W = 2;
   localparam int BYTE_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int NUM_JOINTS = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ANGLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ANGLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE = 2'd2;

   // register reset values
   localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 8'd179;
   localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST = 8'd1;
   localparam logic [STEP_W-1:0]  STEP_SIZE_RST = 3'd2;

   // joint angles after reset
   localparam logic [ANGLE_W-1:0] ANGLE0_RST = 8'd100;
   localparam logic [ANGLE_W-1:0] ANGLE1_RST = 8'd85;
   localparam logic [ANGLE_W-1:0] ANGLE2_RST = 8'd83;
   localparam logic [ANGLE_W-1:0] ANGLE3_RST = 8'd115;

   // request kinds
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_BYTE = 1'b1;

   // command letters
   localparam logic [BYTE_W-1:0] CMD_F = 8'h46;
   localparam logic [BYTE_W-1:0] CMD_B = 8'h42;
   localparam logic [BYTE_W-1:0] CMD_L = 8'h4C;
   localparam logic [BYTE_W-1:0] CMD_R = 8'h52;
   localparam logic [BYTE_W-1:0] CMD_C = 8'h43;
   localparam logic [BYTE_W-1:0] CMD_O = 8'h4F;
   localparam logic [BYTE_W-1:0] CMD_U = 8'h55;
   localparam logic [BYTE_W-1:0] CMD_D = 8'h44;
   localparam logic [BYTE_W-1:0] CMD_S = 8'h53;

   // joint codes
   localparam logic [JOINT_W-1:0] JOINT_REACH   = 2'd0;
   localparam logic [JOINT_W-1:0] JOINT_SWIVEL  = 2'd1;
   localparam logic [JOINT_W-1:0] JOINT_GRIPPER = 2'd2;
   localparam logic [JOINT_W-1:0] JOINT_LIFT    = 2'd3;

   localparam logic [DUTY_W-1:0] DUTY_OFFSET = 9'd60;
   // 683 / 2048 approximates 1/3, exact for dividends up to 1020
   localparam logic [9:0] RECIP_3 = 10'd683;

   typedef struct packed {
      logic [ANGLE_W-1:0] max_angle;
      logic [ANGLE_W-1:0] min_angle;
      logic [STEP_W-1:0]  step_size;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [JOINT_W-1:0] joint;
      logic [DUTY_W-1:0]  duty;
      logic [ANGLE_W-1:0] joint_angle;
   } result_type;

   // duty = floor(angle * 4 / 3) + 60
   function automatic logic [DUTY_W-1:0] duty_of(input logic [ANGLE_W-1:0] angle);
      logic [9:0]  times4;
      logic [19:0] prod;
      begin
         times4  = {angle, 2'b00};
         prod    = {10'd0, times4} * {10'd0, RECIP_3};
         duty_of = prod[19:11] + DUTY_OFFSET;
      end
   endfunction

endpackage
`default_nettype wire

### rtl/core/sjcc_req_if.sv
`default_nettype none
interface sjcc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [sjcc_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface
`default_nettype wire

### rtl/core/sjcc_rsp_if.sv
`default_nettype none
interface sjcc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sjcc_pkg::JOINT_W-1:0]  joint;
   logic [sjcc_pkg::DUTY_W-1:0]   duty;
   logic [sjcc_pkg::ANGLE_W-1:0]  joint_angle;

   modport source (output valid, output joint, output duty, output joint_angle,
                   input ready);
   modport sink   (input valid, input joint, input duty, input joint_angle,
                   output ready);
endinterface
`default_nettype wire

### rtl/core/servo_jog_command_controller.sv
`default_nettype none
// Servo jog controller for four joints. Each req_ch beat is either a 20 ms
// tick (req_type 0) or a received byte (req_type 1). F/B, L/R, C/O and U/D
// start a jog of joints 0..3 up/down, step the angle at once by step_size and
// give one rsp_ch beat with the joint, its new angle and duty
// floor(angle*4/3)+60; each later tick steps again while the angle is below
// max_angle (up) or above min_angle (down), and 'S' ends the jog. Other bytes
// during a jog, ticks while idle and commands already at the limit give no
// beat. Timing: one beat per clock is accepted while req_ch.ready is high;
// a beat passes one input register, the jog logic and one result register
// before rsp_ch.valid rises. req_ch.ready falls only while both registers
// hold a beat and rsp_ch.ready is low. Registers are written through
// csr_we, csr_index (0 max_angle, 1 min_angle, 2 step_size) and csr_wdata;
// the user must write them only while no beat is in flight, as the block
// does not enforce it; indexes beyond 2 are ignored.
module servo_jog_command_controller (
   input  wire logic                             clock,
   input  wire logic                             reset,
   sjcc_req_if.sink                              req_ch,
   sjcc_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [sjcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sjcc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   sjcc_pkg::cfg_type    cfg_ff;
   sjcc_pkg::result_type result;

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_type_ff;
   logic [sjcc_pkg::BYTE_W-1:0]  s1_byte_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sjcc_pkg::JOINT_W-1:0] rsp_joint_ff;
   logic [sjcc_pkg::DUTY_W-1:0]  rsp_duty_ff;
   logic [sjcc_pkg::ANGLE_W-1:0] rsp_angle_ff;
   logic                         out_free;
   logic                         advance;
   logic                         accept;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_angle <= sjcc_pkg::MAX_ANGLE_RST;
         cfg_ff.min_angle <= sjcc_pkg::MIN_ANGLE_RST;
         cfg_ff.step_size <= sjcc_pkg::STEP_SIZE_RST;
      end else if (csr_we) begin
         case (csr_index)
            sjcc_pkg::CSR_MAX_ANGLE: cfg_ff.max_angle <= csr_wdata;
            sjcc_pkg::CSR_MIN_ANGLE: cfg_ff.min_angle <= csr_wdata;
            sjcc_pkg::CSR_STEP_SIZE: cfg_ff.step_size <= csr_wdata[sjcc_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake between input register and result register
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_type_ff <= req_ch.req_type;
         s1_byte_ff <= req_ch.rx_byte;
      end
   end

   // jog state and step logic
   sjcc_jog u_jog (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .req_type (s1_type_ff),
      .rx_byte  (s1_byte_ff),
      .cfg      (cfg_ff),
      .result   (result)
   );

   // result register
   assign rsp_valid_in = out_free ? result.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && result.valid) begin
         rsp_joint_ff <= result.joint;
         rsp_duty_ff  <= result.duty;
         rsp_angle_ff <= result.joint_angle;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.joint       = rsp_joint_ff;
   assign rsp_ch.duty        = rsp_duty_ff;
   assign rsp_ch.joint_angle = rsp_angle_ff;

endmodule
`default_nettype wire

### rtl/core/sjcc_jog.sv
`default_nettype none
module sjcc_jog (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         fire,
   input  wire logic                         req_type,
   input  wire logic [sjcc_pkg::BYTE_W-1:0]  rx_byte,
   input  wire sjcc_pkg::cfg_type            cfg,
   output sjcc_pkg::result_type              result
);

   logic [sjcc_pkg::ANGLE_W-1:0] angles_ff [sjcc_pkg::NUM_JOINTS];
   logic                         moving_ff, moving_in;
   logic [sjcc_pkg::JOINT_W-1:0] active_ff, active_in;
   logic                         up_ff, up_in;

   logic                         cmd_ok;
   logic [sjcc_pkg::JOINT_W-1:0] cmd_joint;
   logic                         cmd_up;
   logic [sjcc_pkg::JOINT_W-1:0] sel_joint;
   logic                         sel_up;
   logic [sjcc_pkg::ANGLE_W-1:0] cur_angle;
   logic [sjcc_pkg::ANGLE_W-1:0] new_angle;
   logic [sjcc_pkg::ANGLE_W:0]   up_sum;
   logic [sjcc_pkg::ANGLE_W-1:0] step_ext;
   logic                         may_now;
   logic                         may_after;
   logic                         step_en;

   // command letter decode
   always_comb begin
      cmd_ok    = 1'b1;
      cmd_joint = sjcc_pkg::JOINT_REACH;
      cmd_up    = 1'b1;
      case (rx_byte)
         sjcc_pkg::CMD_F: begin cmd_joint = sjcc_pkg::JOINT_REACH;   cmd_up = 1'b1; end
         sjcc_pkg::CMD_B: begin cmd_joint = sjcc_pkg::JOINT_REACH;   cmd_up = 1'b0; end
         sjcc_pkg::CMD_L: begin cmd_joint = sjcc_pkg::JOINT_SWIVEL;  cmd_up = 1'b1; end
         sjcc_pkg::CMD_R: begin cmd_joint = sjcc_pkg::JOINT_SWIVEL;  cmd_up = 1'b0; end
         sjcc_pkg::CMD_C: begin cmd_joint = sjcc_pkg::JOINT_GRIPPER; cmd_up = 1'b1; end
         sjcc_pkg::CMD_O: begin cmd_joint = sjcc_pkg::JOINT_GRIPPER; cmd_up = 1'b0; end
         sjcc_pkg::CMD_U: begin cmd_joint = sjcc_pkg::JOINT_LIFT;    cmd_up = 1'b1; end
         sjcc_pkg::CMD_D: begin cmd_joint = sjcc_pkg::JOINT_LIFT;    cmd_up = 1'b0; end
         default:         cmd_ok = 1'b0;
      endcase
   end

   // a byte picks a new jog, a tick continues the active one
   assign sel_joint = (req_type == sjcc_pkg::REQ_BYTE) ? cmd_joint : active_ff;
   assign sel_up    = (req_type == sjcc_pkg::REQ_BYTE) ? cmd_up : up_ff;
   assign cur_angle = angles_ff[sel_joint];
   assign step_ext  = {{(sjcc_pkg::ANGLE_W-sjcc_pkg::STEP_W){1'b0}}, cfg.step_size};

   // saturating step in either direction
   always_comb begin
      up_sum = {1'b0, cur_angle} + {1'b0, step_ext};
      if (sel_up) begin
         new_angle = up_sum[sjcc_pkg::ANGLE_W] ? {sjcc_pkg::ANGLE_W{1'b1}}
                                               : up_sum[sjcc_pkg::ANGLE_W-1:0];
      end else begin
         new_angle = (step_ext > cur_angle) ? '0 : cur_angle - step_ext;
      end
   end

   // jog condition before and after the step
   assign may_now   = sel_up ? (cur_angle < cfg.max_angle) : (cur_angle > cfg.min_angle);
   assign may_after = sel_up ? (new_angle < cfg.max_angle) : (new_angle > cfg.min_angle);

   // next jog state
   always_comb begin
      step_en   = 1'b0;
      moving_in = moving_ff;
      active_in = active_ff;
      up_in     = up_ff;
      if (fire) begin
         if (req_type == sjcc_pkg::REQ_TICK) begin
            if (moving_ff) begin
               step_en   = may_now;
               moving_in = may_now && may_after;
            end
         end else if (moving_ff) begin
            if (rx_byte == sjcc_pkg::CMD_S) begin
               moving_in = 1'b0;
            end
         end else if (cmd_ok && may_now) begin
            step_en   = 1'b1;
            active_in = cmd_joint;
            up_in     = cmd_up;
            moving_in = may_after;
         end
      end
   end

   // jog state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff <= 1'b0;
         active_ff <= sjcc_pkg::JOINT_REACH;
         up_ff     <= 1'b0;
      end else begin
         moving_ff <= moving_in;
         active_ff <= active_in;
         up_ff     <= up_in;
      end
   end

   // joint angles
   always_ff @(posedge clock) begin
      if (reset) begin
         angles_ff[0] <= sjcc_pkg::ANGLE0_RST;
         angles_ff[1] <= sjcc_pkg::ANGLE1_RST;
         angles_ff[2] <= sjcc_pkg::ANGLE2_RST;
         angles_ff[3] <= sjcc_pkg::ANGLE3_RST;
      end else if (step_en) begin
         angles_ff[sel_joint] <= new_angle;
      end
   end

   // result of this item
   assign result.valid       = step_en;
   assign result.joint       = sel_joint;
   assign result.duty        = sjcc_pkg::duty_of(new_angle);
   assign result.joint_angle = new_angle;

endmodule
`default_nettype wire

### rtl/core/sjcc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module sjcc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [sjcc_pkg::JOINT_W-1:0]  rsp_joint,
   input wire logic [sjcc_pkg::DUTY_W-1:0]   rsp_duty,
   input wire logic [sjcc_pkg::ANGLE_W-1:0]  rsp_joint_angle
);

   // duty always agrees with the reported angle
   `ASSERT_ON(a_duty_match, clock, reset, rsp_valid |-> rsp_duty == sjcc_pkg::duty_of(rsp_joint_angle), "duty does not match joint angle")

   // with no result waiting the block always takes a beat
   `ASSERT_ON(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "request stalled with empty result register")

   // a new result needs an earlier accepted beat or a stalled request
   `ASSERT_ON(a_rsp_has_cause, clock, reset, (rsp_valid && !$past(rsp_valid)) |-> $past(req_valid && req_ready, 2) || $past(!req_ready, 2), "result without an accepted beat")

   // a stalled result beat holds
   `ASSERT_ON(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_joint) && $stable(rsp_joint_angle), "stalled result beat changed")

   // reset leaves no result pending
   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind servo_jog_command_controller sjcc_checker u_sjcc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_joint       (rsp_ch.joint),
   .rsp_duty        (rsp_ch.duty),
   .rsp_joint_angle (rsp_ch.joint_angle)
);
`default_nettype wire

### verif/sjcc_move_checker.sv
`timescale 1ns / 100ps

module sjcc_move_checker
   import sjcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sjcc_req_if                   req_ch,
   sjcc_rsp_if                   rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    moves_due
);

   typedef struct packed {
      logic [JOINT_W-1:0] joint;
      logic [DUTY_W-1:0]  duty;
      logic [ANGLE_W-1:0] angle;
   } move_t;

   // register copies
   logic [ANGLE_W-1:0] top_angle;
   logic [ANGLE_W-1:0] bottom_angle;
   logic [STEP_W-1:0]  step_amt;

   // joint and jog state
   logic [ANGLE_W-1:0] joint_angle_q [NUM_JOINTS];
   logic               jogging;
   logic [JOINT_W-1:0] jog_joint;
   logic               jog_up;

   move_t moves_q [$];

   // a jog may go on while the angle is short of the limit in its direction
   function automatic logic jog_allowed(input logic [JOINT_W-1:0] j, input logic up);
      return up ? (joint_angle_q[j] < top_angle) : (joint_angle_q[j] > bottom_angle);
   endfunction

   // move one joint by the step size, saturating at both ends, and queue the beat
   function automatic void step_joint(input logic [JOINT_W-1:0] j, input logic up);
      int    a;
      int    d;
      move_t mv;
      a = joint_angle_q[j];
      if (up) begin
         a = a + step_amt;
         if (a > 255) a = 255;
      end else begin
         a = (step_amt > a) ? 0 : a - step_amt;
      end
      d = (a * 4) / 3 + 60;
      joint_angle_q[j] = a[ANGLE_W-1:0];
      mv.joint = j;
      mv.duty  = d[DUTY_W-1:0];
      mv.angle = a[ANGLE_W-1:0];
      moves_q.push_back(mv);
   endfunction

   // apply one accepted request beat to the jog state
   function automatic void track_request(input logic kind, input logic [BYTE_W-1:0] b);
      logic [JOINT_W-1:0] j;
      logic               up;
      logic               known;
      j = JOINT_REACH;
      up = 1'b0;
      known = 1'b1;
      if (kind == REQ_TICK) begin
         if (jogging) begin
            if (!jog_allowed(jog_joint, jog_up)) begin
               jogging = 1'b0;
            end else begin
               step_joint(jog_joint, jog_up);
               jogging = jog_allowed(jog_joint, jog_up);
            end
         end
      end else if (jogging) begin
         // only stop ends a jog, anything else is dropped
         if (b == CMD_S) jogging = 1'b0;
      end else begin
         case (b)
            CMD_F: begin j = JOINT_REACH;   up = 1'b1; end
            CMD_B: begin j = JOINT_REACH;   up = 1'b0; end
            CMD_L: begin j = JOINT_SWIVEL;  up = 1'b1; end
            CMD_R: begin j = JOINT_SWIVEL;  up = 1'b0; end
            CMD_C: begin j = JOINT_GRIPPER; up = 1'b1; end
            CMD_O: begin j = JOINT_GRIPPER; up = 1'b0; end
            CMD_U: begin j = JOINT_LIFT;    up = 1'b1; end
            CMD_D: begin j = JOINT_LIFT;    up = 1'b0; end
            default: known = 1'b0;
         endcase
         if (known && jog_allowed(j, up)) begin
            jog_joint = j;
            jog_up = up;
            step_joint(j, up);
            jogging = jog_allowed(j, up);
         end
      end
   endfunction

   always @(posedge clock) begin
      move_t got;
      move_t want;
      if (reset) begin
         top_angle    = MAX_ANGLE_RST;
         bottom_angle = MIN_ANGLE_RST;
         step_amt     = STEP_SIZE_RST;
         joint_angle_q[JOINT_REACH]   = ANGLE0_RST;
         joint_angle_q[JOINT_SWIVEL]  = ANGLE1_RST;
         joint_angle_q[JOINT_GRIPPER] = ANGLE2_RST;
         joint_angle_q[JOINT_LIFT]    = ANGLE3_RST;
         jogging   = 1'b0;
         jog_joint = JOINT_REACH;
         jog_up    = 1'b0;
         moves_q.delete();
         mismatches <= 0;
      end else begin
         // register writes, unused indexes fall through
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_ANGLE: top_angle    = csr_wdata;
               CSR_MIN_ANGLE: bottom_angle = csr_wdata;
               CSR_STEP_SIZE: step_amt     = csr_wdata[STEP_W-1:0];
               default: ;
            endcase
         end
         // result beat against the oldest predicted move
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.joint = rsp_ch.joint;
            got.duty  = rsp_ch.duty;
            got.angle = rsp_ch.joint_angle;
            if (moves_q.size() == 0) begin
               $display("%0t: unexpected result beat joint %0d duty %0d angle %0d",
                        $time, got.joint, got.duty, got.angle);
               mismatches <= mismatches + 1;
            end else begin
               want = moves_q.pop_front();
               if (got !== want) begin
                  $display("%0t: result mismatch expected joint %0d duty %0d angle %0d, %s",
                           $time, want.joint, want.duty, want.angle, "see actual below");
                  $display("%0t:                 actual   joint %0d duty %0d angle %0d",
                           $time, got.joint, got.duty, got.angle);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) track_request(req_ch.req_type, req_ch.rx_byte);
      end
      moves_due <= moves_q.size();
   end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import sjcc_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 12;
   localparam int IDLE_PCT      = 26;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int PHASE_ITEMS   = 100;
   localparam int STEADY_PHASE  = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic rsp_take = 1'b0;
   logic steady = 1'b0;
   int   mismatches;
   int   moves_due;
   int   stall_cycles = 0;

   sjcc_req_if req_ch ();
   sjcc_rsp_if rsp_ch ();

   assign rsp_ch.ready = rsp_take;

   servo_jog_command_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sjcc_move_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .moves_due  (moves_due)
   );

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // result side stalls at random unless in the steady stretch
   always @(negedge clock) begin
      rsp_take <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one request beat, with random gaps ahead of it
   task automatic send_beat(input logic kind, input logic [BYTE_W-1:0] data);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.rx_byte  <= data;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold off until every predicted move is out and the pipe has emptied
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (moves_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [BYTE_W-1:0] jog_letter(input int pick);
      case (pick)
         0: return CMD_F;
         1: return CMD_B;
         2: return CMD_L;
         3: return CMD_R;
         4: return CMD_C;
         5: return CMD_O;
         6: return CMD_U;
         default: return CMD_D;
      endcase
   endfunction

   // limits per phase: extremes first, then mostly wide ranges for long jogs
   task automatic choose_settings(input int phase);
      logic [ANGLE_W-1:0] top;
      logic [ANGLE_W-1:0] bottom;
      logic [STEP_W-1:0]  stride;
      stride = STEP_W'(1 + $urandom_range(3));
      case ($urandom_range(5))
         0: begin top = 8'd179; bottom = 8'd0; end
         1: begin
            top    = ANGLE_W'(1 + $urandom_range(178));
            bottom = ANGLE_W'($urandom_range(178));
         end
         default: begin
            top    = ANGLE_W'(150 + $urandom_range(29));
            bottom = ANGLE_W'($urandom_range(30));
         end
      endcase
      if (phase == 0) begin
         top = 8'd179; bottom = 8'd0; stride = 3'd4;
      end else if (phase == 1) begin
         top = 8'd179; bottom = 8'd0; stride = 3'd1;
      end
      write_reg(CSR_MAX_ANGLE, top);
      write_reg(CSR_MIN_ANGLE, bottom);
      write_reg(CSR_STEP_SIZE, CSR_DATA_W'(stride));
      if (phase % 5 == 2) write_reg(CSR_SPARE, CSR_DATA_W'($urandom_range(255)));
   endtask

   // jog sequences: a command, a run of ticks with some stray bytes, often a stop
   task automatic jog_phase(input int quota, inout int counted);
      int done;
      int run;
      done = 0;
      while (done < quota) begin
         if ($urandom_range(99) < 10) begin
            if ($urandom_range(1) == 0) send_beat(REQ_TICK, BYTE_W'($urandom_range(255)));
            else send_beat(REQ_BYTE, BYTE_W'($urandom_range(255)));
         end else begin
            send_beat(REQ_BYTE, jog_letter($urandom_range(7)));
            done++;
            run = ($urandom_range(9) == 0) ? $urandom_range(180) : $urandom_range(30);
            repeat (run) begin
               if ($urandom_range(99) < 5) begin
                  send_beat(REQ_BYTE, BYTE_W'($urandom_range(255)));
               end else begin
                  send_beat(REQ_TICK, BYTE_W'($urandom_range(255)));
                  done++;
               end
            end
            if ($urandom_range(2) != 0) send_beat(REQ_BYTE, CMD_S);
         end
      end
      counted += done;
   endtask

   initial begin
      int counted;
      int phase;
      counted = 0;
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_TICK;
      req_ch.rx_byte  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_MAX_ANGLE;
      csr_wdata = '0;
      reset     = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle cases: tick, stop, lowercase and unknown bytes
      send_beat(REQ_TICK, 8'hFF);
      send_beat(REQ_BYTE, CMD_S);
      send_beat(REQ_BYTE, 8'h66);
      send_beat(REQ_BYTE, 8'h00);
      send_beat(REQ_BYTE, 8'hFF);
      // jog with bytes dropped mid-jog, then stop and a tick while idle
      send_beat(REQ_BYTE, CMD_F);
      send_beat(REQ_TICK, 8'h00);
      send_beat(REQ_BYTE, CMD_B);
      send_beat(REQ_BYTE, 8'h80);
      send_beat(REQ_TICK, 8'h00);
      send_beat(REQ_BYTE, CMD_S);
      send_beat(REQ_TICK, 8'h00);
      // the other command letters
      send_beat(REQ_BYTE, CMD_L);
      send_beat(REQ_BYTE, CMD_S);
      send_beat(REQ_BYTE, CMD_R);
      send_beat(REQ_TICK, 8'h00);
      send_beat(REQ_BYTE, CMD_S);
      send_beat(REQ_BYTE, CMD_C);
      send_beat(REQ_BYTE, CMD_S);
      send_beat(REQ_BYTE, CMD_O);
      send_beat(REQ_BYTE, CMD_S);
      send_beat(REQ_BYTE, CMD_D);
      send_beat(REQ_BYTE, CMD_S);
      send_beat(REQ_BYTE, CMD_U);
      send_beat(REQ_TICK, 8'h00);
      // limit pulled under a running jog, then commands already at the limit
      settle();
      write_reg(CSR_MAX_ANGLE, 8'd1);
      send_beat(REQ_TICK, 8'h00);
      send_beat(REQ_BYTE, CMD_U);
      settle();
      write_reg(CSR_MIN_ANGLE, 8'd178);
      send_beat(REQ_BYTE, CMD_D);

      // random phases, one of them without any idling
      for (phase = 0; counted < RANDOM_ITEMS; phase++) begin
         settle();
         steady = (phase == STEADY_PHASE);
         choose_settings(phase);
         jog_phase(PHASE_ITEMS, counted);
      end
      steady = 1'b0;

      settle();
      if (mismatches == 0 && moves_due == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
